@@ rtl/core/linear_probe_hash_table_defines.svh @@
// Assertion helpers used by the checker file.
`ifndef LINEAR_PROBE_HASH_TABLE_DEFINES_SVH
`define LINEAR_PROBE_HASH_TABLE_DEFINES_SVH

// Clocked assertion, off while reset is asserted.
`define LPHT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define LPHT_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/lpht_pkg.sv @@
package lpht_pkg;

  localparam int unsigned TableSlots = 16;
  localparam int unsigned SlotW      = (TableSlots > 1) ? $clog2(TableSlots) : 1;
  localparam int unsigned KeyW       = 32;
  localparam int unsigned StatusW    = 3;
  localparam int unsigned OutSlotW   = 4;
  localparam int unsigned OutDataW   = 8;

  typedef enum logic [StatusW-1:0] {
    STAT_INSERTED  = 3'd0,
    STAT_FULL      = 3'd1,
    STAT_FOUND     = 3'd2,
    STAT_NOT_FOUND = 3'd3,
    STAT_ZERO_KEY  = 3'd4
  } lpht_status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_READ,
    S_CHECK,
    S_RESULT
  } lpht_state_e;

endpackage

@@ rtl/core/linear_probe_hash_table.sv @@
// Channel  Dir  tdata                     tuser
// s_axis   in   [31:0] key (signed)       [0] mode: 0 insert, 1 search
// m_axis   out  [3:0] slot, [7:4] zero    [2:0] status
//
// After reset a clearing pass writes zero to every slot, one slot per cycle;
// s_axis_tready stays low until it is done.
// A nonzero key is worked in steps: its magnitude is reduced to the home slot,
// the table read is primed, then n (1 to 16) slots are probed, one per cycle,
// through the single read port, and the result is loaded into the output register.
// A zero key skips hashing and probing and goes straight to the output register load.
// One item is worked at a time; s_axis_tready is high only while idle. A
// finished result waits in the output register, so the next item is taken
// while m_axis is stalled; a second result then holds until the first is taken.
module linear_probe_hash_table (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [lpht_pkg::KeyW-1:0]           s_axis_tdata,  // [31:0] key
  input  logic                                s_axis_tuser,  // [0] mode
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [lpht_pkg::OutDataW-1:0]       m_axis_tdata,  // [3:0] slot, [7:4] zero
  output logic [lpht_pkg::StatusW-1:0]        m_axis_tuser   // [2:0] status
);

  localparam int unsigned SlotW   = lpht_pkg::SlotW;
  localparam int unsigned KeyW    = lpht_pkg::KeyW;

  // Sequencer and control
  lpht_pkg::lpht_state_e state_q, state_d;
  logic                  out_valid_q, out_valid_d;

  // Working registers (payload; only probe_q has a reset)
  logic [SlotW-1:0]                  probe_q, probe_d;
  logic [SlotW-1:0]                  cnt_q, cnt_d;
  logic [KeyW-1:0]                   mag_q, mag_d;
  logic [KeyW-1:0]                   key_q, key_d;
  logic                              mode_q, mode_d;
  lpht_pkg::lpht_status_e            res_status_q, res_status_d;
  logic [SlotW-1:0]                  res_slot_q, res_slot_d;
  lpht_pkg::lpht_status_e            out_status_q, out_status_d;
  logic [lpht_pkg::OutSlotW-1:0]     out_slot_q, out_slot_d;

  // Table storage, one read and one write port
  logic [KeyW-1:0]  mem_q [lpht_pkg::TableSlots];
  logic [KeyW-1:0]  rd_data_q;
  logic [SlotW-1:0] rd_addr;
  logic             mem_we;
  logic [KeyW-1:0]  mem_wdata;

  logic [SlotW-1:0] probe_next;
  logic             slot_empty;
  logic             key_hit;
  logic             last_probe;

  // Wrap to slot zero past the last slot
  assign probe_next = (probe_q == SlotW'(lpht_pkg::TableSlots - 1)) ? '0 : probe_q + 1'b1;

  assign slot_empty = (rd_data_q == '0);
  assign key_hit    = (rd_data_q == key_q);
  assign last_probe = (cnt_q == SlotW'(lpht_pkg::TableSlots - 1));

  // Read one slot ahead while probing so that each cycle checks a new slot
  assign rd_addr   = (state_q == lpht_pkg::S_CHECK) ? probe_next : probe_q;
  assign mem_wdata = (state_q == lpht_pkg::S_CLEAR) ? '0 : key_q;

  always_comb begin
    state_d      = state_q;
    out_valid_d  = out_valid_q;
    probe_d      = probe_q;
    cnt_d        = cnt_q;
    mag_d        = mag_q;
    key_d        = key_q;
    mode_d       = mode_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    out_status_d = out_status_q;
    out_slot_d   = out_slot_q;
    mem_we       = 1'b0;

    // Drop the output once it has been taken
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      lpht_pkg::S_CLEAR: begin
        mem_we  = 1'b1;
        probe_d = probe_next;
        if (probe_q == SlotW'(lpht_pkg::TableSlots - 1)) begin
          state_d = lpht_pkg::S_IDLE;
        end
      end

      lpht_pkg::S_IDLE: begin
        if (s_axis_tvalid) begin
          key_d     = s_axis_tdata;
          mode_d    = s_axis_tuser;
          // Magnitude of the most negative key wraps to 2^31 unsigned
          mag_d     = s_axis_tdata[KeyW-1] ? (KeyW'(0) - s_axis_tdata) : s_axis_tdata;
          if (s_axis_tdata == '0) begin
            res_status_d = lpht_pkg::STAT_ZERO_KEY;
            res_slot_d   = '0;
            state_d      = lpht_pkg::S_RESULT;
          end else begin
            state_d = lpht_pkg::S_HASH;
          end
        end
      end

      lpht_pkg::S_HASH: begin
        // Home slot: magnitude modulo the table size
        probe_d = SlotW'(mag_q % lpht_pkg::TableSlots);
        cnt_d   = '0;
        state_d = lpht_pkg::S_READ;
      end

      lpht_pkg::S_READ: begin
        state_d = lpht_pkg::S_CHECK;
      end

      lpht_pkg::S_CHECK: begin
        if (!mode_q) begin
          priority if (slot_empty) begin
            mem_we       = 1'b1;
            res_status_d = lpht_pkg::STAT_INSERTED;
            res_slot_d   = probe_q;
            state_d      = lpht_pkg::S_RESULT;
          end else if (last_probe) begin
            res_status_d = lpht_pkg::STAT_FULL;
            res_slot_d   = '0;
            state_d      = lpht_pkg::S_RESULT;
          end else begin
            probe_d = probe_next;
            cnt_d   = cnt_q + 1'b1;
          end
        end else begin
          priority if (slot_empty) begin
            res_status_d = lpht_pkg::STAT_NOT_FOUND;
            res_slot_d   = '0;
            state_d      = lpht_pkg::S_RESULT;
          end else if (key_hit) begin
            res_status_d = lpht_pkg::STAT_FOUND;
            res_slot_d   = probe_q;
            state_d      = lpht_pkg::S_RESULT;
          end else if (last_probe) begin
            res_status_d = lpht_pkg::STAT_NOT_FOUND;
            res_slot_d   = '0;
            state_d      = lpht_pkg::S_RESULT;
          end else begin
            probe_d = probe_next;
            cnt_d   = cnt_q + 1'b1;
          end
        end
      end

      lpht_pkg::S_RESULT: begin
        // Hold until the output register is free
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_slot_d   = lpht_pkg::OutSlotW'(res_slot_q);
          state_d      = lpht_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = lpht_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lpht_pkg::S_CLEAR;
      out_valid_q <= 1'b0;
      probe_q     <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      probe_q     <= probe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q        <= cnt_d;
    mag_q        <= mag_d;
    key_q        <= key_d;
    mode_q       <= mode_d;
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    out_status_q <= out_status_d;
    out_slot_q   <= out_slot_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[probe_q] <= mem_wdata;
    end
    rd_data_q <= mem_q[rd_addr];
  end

  assign s_axis_tready = (state_q == lpht_pkg::S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(lpht_pkg::OutDataW - lpht_pkg::OutSlotW)'(0), out_slot_q};
  assign m_axis_tuser  = out_status_q;

endmodule

@@ rtl/core/lpht_checker.sv @@
`include "linear_probe_hash_table_defines.svh"

module lpht_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               s_axis_tvalid,
  input logic                               s_axis_tready,
  input logic                               m_axis_tvalid,
  input logic                               m_axis_tready,
  input logic [lpht_pkg::OutDataW-1:0]      m_axis_tdata,   // [3:0] slot, [7:4] zero
  input logic [lpht_pkg::StatusW-1:0]       m_axis_tuser    // [2:0] status
);

  // Results that carry no slot
  logic miss_result;

  assign miss_result = (m_axis_tuser != lpht_pkg::STAT_INSERTED) &&
                       (m_axis_tuser != lpht_pkg::STAT_FOUND);

  `LPHT_ASSERT_NR(a_status_legal, clk_i, m_axis_tvalid |-> (m_axis_tuser <= lpht_pkg::STAT_ZERO_KEY), "illegal status code")

  `LPHT_ASSERT(a_busy_after_transfer, clk_i, rst_ni, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready, "ready stayed high after an input transfer")

  `LPHT_ASSERT(a_out_hold, clk_i, rst_ni, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)), "stalled result changed")

  `LPHT_ASSERT(a_slot_zero, clk_i, rst_ni, (m_axis_tvalid && miss_result) |-> (m_axis_tdata == '0), "slot not zero on a miss")

endmodule

bind linear_probe_hash_table lpht_checker u_lpht_checker (.*);

@@ tb/sv/linear_probe_hash_table_tb.sv @@
`timescale 1ns / 100ps

module linear_probe_hash_table_tb;

  localparam int unsigned HalfPeriod = 6;
  localparam int unsigned RandomItems = 1250;
  localparam int unsigned LongHold = 300;
  localparam int unsigned IdleLimit = 2000;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned KeyW = lpht_pkg::KeyW;
  localparam int unsigned TableSlots = lpht_pkg::TableSlots;
  localparam int unsigned OutSlotW = lpht_pkg::OutSlotW;
  localparam int unsigned OutDataW = lpht_pkg::OutDataW;
  localparam int unsigned StatusW = lpht_pkg::StatusW;

  // Expected answer for one request.
  typedef struct packed {
    lpht_pkg::lpht_status_e status;
    logic [OutSlotW-1:0]    slot;
  } answer_t;

  // Shadow of the slot store; predicts each answer as the request is taken.
  class probe_table_model;
    logic [KeyW-1:0] slots [TableSlots];
    answer_t         pending_answers [$];
    int unsigned     errors;

    function new();
      foreach (slots[i]) slots[i] = '0;
      errors = 0;
    endfunction

    function void note_request(bit search, logic [KeyW-1:0] key);
      answer_t         ans;
      logic [KeyW-1:0] magnitude;
      int unsigned     s;
      ans.slot = '0;
      if (key == '0) begin
        ans.status = lpht_pkg::STAT_ZERO_KEY;
      end else begin
        // Most negative key wraps to magnitude 2^31, taken as unsigned.
        magnitude  = key[KeyW-1] ? (32'd0 - key) : key;
        s          = magnitude % TableSlots;
        ans.status = search ? lpht_pkg::STAT_NOT_FOUND : lpht_pkg::STAT_FULL;
        for (int n = 0; n < TableSlots; n++) begin
          if (slots[s] == '0) begin
            if (!search) begin
              slots[s]   = key;
              ans.status = lpht_pkg::STAT_INSERTED;
              ans.slot   = s[OutSlotW-1:0];
            end
            break;
          end
          if (search && slots[s] == key) begin
            ans.status = lpht_pkg::STAT_FOUND;
            ans.slot   = s[OutSlotW-1:0];
            break;
          end
          s = (s + 1 >= TableSlots) ? 0 : s + 1;
        end
      end
      pending_answers.push_back(ans);
    endfunction

    function void check_answer(logic [StatusW-1:0] status, logic [OutDataW-1:0] data);
      answer_t ans;
      if (pending_answers.size() == 0) begin
        errors++;
        $display("%0t unexpected result: status %0d tdata 0x%02h", $time, status, data);
        return;
      end
      ans = pending_answers.pop_front();
      if (status !== ans.status) begin
        errors++;
        $display("%0t status mismatch: expected %0d, got %0d", $time, ans.status, status);
      end
      if (data !== {{(OutDataW-OutSlotW){1'b0}}, ans.slot}) begin
        errors++;
        $display("%0t slot mismatch: expected tdata 0x%02h, got 0x%02h", $time,
                 {{(OutDataW-OutSlotW){1'b0}}, ans.slot}, data);
      end
    endfunction

    function int unsigned outstanding();
      return pending_answers.size();
    endfunction

    function void close();
      if (pending_answers.size() != 0) begin
        errors++;
        $display("%0t %0d expected results never arrived", $time, pending_answers.size());
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [KeyW-1:0]     s_axis_tdata;   // [31:0] key
  logic                s_axis_tuser;   // [0] mode: 0 insert, 1 search
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;   // [3:0] slot, [7:4] zero
  logic [StatusW-1:0]  m_axis_tuser;   // [2:0] status

  probe_table_model table_model;
  logic [KeyW-1:0]  inserted_keys [$];
  int unsigned      burst_left;
  int unsigned      idle_cycles;
  bit               hold_req;
  bit               hold_done;

  linear_probe_hash_table dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial clk_i = 1'b0;
  always #(HalfPeriod) clk_i = ~clk_i;

  // Offer one request from a falling edge, hold it until the transfer, then
  // keep valid high inside a burst or drop it for a random gap between bursts.
  task automatic send_request(input bit search, input logic [KeyW-1:0] key);
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = search;
    s_axis_tdata  = key;
    do @(posedge clk_i); while (!s_axis_tready);
    table_model.note_request(search, key);
    if (!search) inserted_keys.push_back(key);
    @(negedge clk_i);
    if (burst_left == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk_i);
      burst_left = $urandom_range(1, 40);
    end else begin
      burst_left--;
    end
  endtask

  // Mix of full-width keys, small keys that pile onto few home slots, and
  // the most negative key.
  function automatic logic [KeyW-1:0] random_key();
    logic [KeyW-1:0] k;
    case ($urandom_range(0, 7))
      0, 1, 2: k = $urandom;
      3, 4:    k = $urandom_range(1, 64);
      5, 6:    k = 32'd0 - $urandom_range(1, 64);
      default: k = 32'h8000_0000;
    endcase
    return k;
  endfunction

  // Receiver: own stall pattern in phases, plus one long hold on request.
  initial begin
    int unsigned phase;
    int unsigned phase_left;
    int unsigned held;
    phase         = 0;
    phase_left    = 0;
    held          = 0;
    hold_done     = 1'b0;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_done) begin
        m_axis_tready = 1'b0;
        held++;
        if (held >= LongHold) hold_done = 1'b1;
      end else begin
        if (phase_left == 0) begin
          phase      = $urandom_range(0, 2);
          phase_left = $urandom_range(10, 60);
        end
        phase_left--;
        case (phase)
          0:       m_axis_tready = 1'b1;
          1:       m_axis_tready = 1'($urandom_range(0, 1));
          default: m_axis_tready = ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  // Check each result transfer against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      table_model.check_answer(m_axis_tuser, m_axis_tdata);
  end

  // Watchdog: end the run if no transfer happens on either side for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("%0t timeout: no transfer for %0d cycles", $time, idle_cycles);
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int unsigned     pick;
    logic [KeyW-1:0] key;
    table_model   = new();
    burst_left    = 0;
    idle_cycles   = 0;
    hold_req      = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: zero key in both modes, empty-table miss, wrap-around probing
    // from the last slot, the most negative key, the field extremes and a
    // duplicate insert.
    send_request(1'b0, 32'd0);
    send_request(1'b1, 32'd0);
    send_request(1'b1, 32'd5);
    send_request(1'b0, 32'd15);
    send_request(1'b0, 32'd0 - 32'd31);
    send_request(1'b0, 32'h8000_0000);
    send_request(1'b1, 32'h8000_0000);
    send_request(1'b1, 32'd47);
    send_request(1'b0, 32'h7fff_ffff);
    send_request(1'b0, 32'h8000_0001);
    send_request(1'b1, 32'h7fff_ffff);
    send_request(1'b1, 32'h8000_0001);
    send_request(1'b0, 32'd15);
    send_request(1'b1, 32'd15);
    send_request(1'b1, 32'd0 - 32'd31);
    send_request(1'b0, 32'hffff_ffff);
    send_request(1'b1, 32'hffff_ffff);
    send_request(1'b1, 32'd1);

    // Random: mostly searches of stored keys with a trickle of inserts, so the
    // table fills slowly and then serves full-table inserts and searches.
    for (int i = 0; i < RandomItems; i++) begin
      if (i == 300) hold_req = 1'b1;
      if (i == 700) begin
        s_axis_tvalid = 1'b0;
        while (table_model.outstanding() != 0) @(posedge clk_i);
        @(negedge clk_i);
      end
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        send_request(1'b0, random_key());
      end else if (pick < 8) begin
        send_request(1'($urandom_range(0, 1)), 32'd0);
      end else if (pick < 60 && inserted_keys.size() != 0) begin
        key = inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
        // Negate now and then: same home slot, a different key but for the most negative one.
        if ($urandom_range(0, 4) == 0) key = 32'd0 - key;
        send_request(1'b1, key);
      end else begin
        send_request(1'b1, random_key());
      end
    end

    s_axis_tvalid = 1'b0;
    while (table_model.outstanding() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    table_model.close();
    if (table_model.errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
